FILE: src/rht_pkg.sv
`default_nettype none

package rht_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned PTR_BITS    = 9;
  localparam int unsigned DATUM_BITS  = 32;
  localparam int unsigned COUNT_BITS  = 16;

  localparam logic [PTR_BITS-1:0] DEPTH_PTR = PTR_BITS'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DROP   = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic [HANDLE_BITS-1:0] handle;
    logic [DATUM_BITS-1:0]  datum;
    logic [COUNT_BITS-1:0]  ref_amount;
  } req_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] result_handle;
    logic                   ok;
    logic [DATUM_BITS-1:0]  result_datum;
    logic                   released;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: src/refcounted_handle_table.sv
`default_nettype none

// Reference-counted handle table. An item is accepted when start is high and
// busy is low; its result appears on rsp_o for exactly one cycle with
// rsp_valid_o high, and the receiver cannot stall it. An item first reads the
// entry memories and the free stack top, then updates them and registers its
// result; busy is high during the update, so the next item waits for it to end.
// Handle 0 reports a failed insert; a drop that frees a handle returns its datum.
module refcounted_handle_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rht_pkg::req_t req_i,
  output rht_pkg::rsp_t      rsp_o,
  output logic               rsp_valid_o
);
  import rht_pkg::*;

  ctrl_cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  rht_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

`default_nettype wire

FILE: src/rht_ctrl.sv
`default_nettype none

module rht_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  output rht_pkg::ctrl_cmd_t      cmd_o
);
  import rht_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rht_datapath.sv
`default_nettype none

module rht_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rht_pkg::ctrl_cmd_t cmd_i,
  input  wire rht_pkg::req_t      req_i,
  output rht_pkg::rsp_t           rsp_o,
  output logic                    rsp_valid_o
);
  import rht_pkg::*;

  logic [DATUM_BITS-1:0]  datum_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]  count_mem [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] stack_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] live_q;
  logic [PTR_BITS-1:0]    fresh_q, fresh_d;
  logic [PTR_BITS-1:0]    top_q, top_d;

  req_t                   req_q;
  logic [DATUM_BITS-1:0]  datum_rd_q;
  logic [COUNT_BITS-1:0]  count_rd_q;
  logic [HANDLE_BITS-1:0] stack_rd_q;

  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q;

  logic [PTR_BITS-1:0]    top_dec;
  logic                   handle_live;
  logic [HANDLE_BITS-1:0] slot;
  logic                   slot_ok;
  logic [COUNT_BITS:0]    sum;
  logic [COUNT_BITS-1:0]  dec;
  logic                   datum_we;
  logic                   count_we;
  logic [HANDLE_BITS-1:0] count_addr;
  logic [COUNT_BITS-1:0]  count_wdata;
  logic                   stack_we;
  logic                   live_set;
  logic                   live_clr;

  assign top_dec = top_q - PTR_BITS'(1);

  // Reads are taken when an item is accepted; the stack read anticipates a pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q      <= req_i;
      datum_rd_q <= datum_mem[req_i.handle];
      count_rd_q <= count_mem[req_i.handle];
      stack_rd_q <= stack_mem[top_dec[HANDLE_BITS-1:0]];
    end
  end

  assign handle_live = (req_q.handle != '0) && live_q[req_q.handle];
  assign sum = {1'b0, count_rd_q} + {1'b0, req_q.ref_amount};
  assign dec = count_rd_q - COUNT_BITS'(1);

  always_comb begin
    fresh_d     = fresh_q;
    top_d       = top_q;
    slot        = '0;
    slot_ok     = 1'b0;
    datum_we    = 1'b0;
    count_we    = 1'b0;
    count_addr  = req_q.handle;
    count_wdata = '0;
    stack_we    = 1'b0;
    live_set    = 1'b0;
    live_clr    = 1'b0;
    rsp_d.result_handle = req_q.handle;
    rsp_d.ok            = 1'b0;
    rsp_d.result_datum  = '0;
    rsp_d.released      = 1'b0;

    unique case (req_q.mode)
      MODE_INSERT: begin
        // The most recently freed handle goes out first.
        if (top_q != '0) begin
          top_d = top_dec;
          slot  = stack_rd_q;
        end else if (fresh_q < DEPTH_PTR) begin
          fresh_d = fresh_q + PTR_BITS'(1);
          slot    = fresh_q[HANDLE_BITS-1:0];
        end
        slot_ok = (slot != '0);
        rsp_d.result_handle = slot_ok ? slot : '0;
        rsp_d.ok            = slot_ok;
        datum_we    = slot_ok;
        count_we    = slot_ok;
        count_addr  = slot;
        count_wdata = req_q.ref_amount;
        live_set    = slot_ok;
      end
      MODE_ADD: begin
        if (handle_live) begin
          count_we    = 1'b1;
          count_wdata = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
          rsp_d.ok    = 1'b1;
        end
      end
      MODE_DROP: begin
        if (handle_live) begin
          count_we    = 1'b1;
          count_wdata = dec;
          if (dec == '0) begin
            live_clr           = 1'b1;
            rsp_d.result_datum = datum_rd_q;
            rsp_d.released     = 1'b1;
            if (top_q < DEPTH_PTR) begin
              stack_we = 1'b1;
              top_d    = top_q + PTR_BITS'(1);
            end
          end else begin
            rsp_d.ok = 1'b1;
          end
        end
      end
      MODE_LOOKUP: begin
        if (handle_live) begin
          rsp_d.ok           = 1'b1;
          rsp_d.result_datum = datum_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (datum_we) begin
        datum_mem[slot] <= req_q.datum;
      end
      if (count_we) begin
        count_mem[count_addr] <= count_wdata;
      end
      if (stack_we) begin
        stack_mem[top_q[HANDLE_BITS-1:0]] <= req_q.handle;
      end
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      fresh_q     <= PTR_BITS'(1);
      top_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        fresh_q <= fresh_d;
        top_q   <= top_d;
        if (live_set) begin
          live_q[slot] <= 1'b1;
        end
        if (live_clr) begin
          live_q[req_q.handle] <= 1'b0;
        end
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire
